>>> rtl/core/pkiu_pkg.sv
// ----------------------------------------------------------------------------
// pkiu_pkg: shared types and constants of the palette keyed upscaler
// Beat formats, register indexes, item codes and palette request struct.
// ----------------------------------------------------------------------------
package pkiu_pkg;

  // palette geometry
  localparam int unsigned PAL_ENTRIES = 256;
  localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int unsigned COLOUR_W    = 24;

  // scale limits and counter width
  localparam int unsigned MAX_SCALE = 8;
  localparam int unsigned SCALE_W   = 4;
  localparam int unsigned KCNT_W    = $clog2(MAX_SCALE);

  // field widths
  localparam int unsigned SRC_W  = 12;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned TGT_W  = 16;
  localparam int unsigned DST_W  = 15;
  localparam int unsigned PROD_W = 17;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE         = 3'd0,
    CFG_SOURCE_WIDTH  = 3'd1,
    CFG_SOURCE_HEIGHT = 3'd2,
    CFG_TARGET_WIDTH  = 3'd3,
    CFG_TARGET_HEIGHT = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    FUNC_PALETTE = 1'b0,
    FUNC_PIXEL   = 1'b1
  } func_e;

  localparam logic [PAL_AW-1:0] IDX_TRANSPARENT = '0;

  typedef struct packed {
    logic                func;
    logic [SRC_W-1:0]    src_x;
    logic [SRC_W-1:0]    src_y;
    logic [PAL_AW-1:0]   pixel_index;
    logic [COLOUR_W-1:0] entry_colour;
  } in_beat_t;

  typedef struct packed {
    logic [DST_W-1:0]    dst_x;
    logic [DST_W-1:0]    dst_y;
    logic [COLOUR_W-1:0] colour;
    logic                last;
  } out_beat_t;

  // palette access: one write or one read per item
  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [PAL_AW-1:0]   addr;
    logic [COLOUR_W-1:0] wdata;
  } pal_req_t;

endpackage

>>> rtl/core/pkiu_palette.sv
// ----------------------------------------------------------------------------
// pkiu_palette: colour table of the upscaler
// Single port table with registered read. Per-entry valid flags make every
// entry read as black after reset until it is first written.
// ----------------------------------------------------------------------------
module pkiu_palette (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pkiu_pkg::pal_req_t            req_i,
  output logic [pkiu_pkg::COLOUR_W-1:0] rdata_o
);
  import pkiu_pkg::*;

  logic [COLOUR_W-1:0]    mem [PAL_ENTRIES];
  logic [PAL_ENTRIES-1:0] vld_q;
  logic [COLOUR_W-1:0]    rd_q;
  logic                   rd_vld_q;

  // table storage and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.addr];
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

>>> rtl/core/palette_keyed_integer_upscaler_top.sv
// ----------------------------------------------------------------------------
// palette_keyed_integer_upscaler_top: indexed layer upscaler
// Looks pixels up in a colour table and writes each as a scale x scale block.
//
//   channel  | signals                                   | beat
//   ---------+-------------------------------------------+-----------------
//   in       | in_valid_i, in_stall_o, in_data_i         | palette or pixel
//   out      | out_valid_o, out_stall_i, out_data_o      | destination write
//   cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i/data| register write
//
// A palette write or a transparent pixel is done on acceptance; a pixel
// clipped in x ends after the x check, one clipped in y after the y check;
// for an opaque pixel one multiply-compare unit checks x then y and forms the
// base coordinates, then one write beat leaves per cycle while out is free.
// Output stalls hold the sequencer; the input is stalled while an item runs.
// Reset makes every colour entry black through per-entry flags, no sweep.
// ----------------------------------------------------------------------------
module palette_keyed_integer_upscaler_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pkiu_pkg::in_beat_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pkiu_pkg::out_beat_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pkiu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pkiu_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pkiu_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLIPX = 4'b0010,
    ST_CLIPY = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [SCALE_W-1:0] scale_q;
  logic [SIZE_W-1:0]  src_w_q, src_h_q;
  logic [TGT_W-1:0]   tgt_w_q, tgt_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_W'(1);
      src_w_q <= SIZE_W'(320);
      src_h_q <= SIZE_W'(200);
      tgt_w_q <= TGT_W'(320);
      tgt_h_q <= TGT_W'(200);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCALE:         scale_q <= cfg_data_i[SCALE_W-1:0];
        CFG_SOURCE_WIDTH:  src_w_q <= cfg_data_i[SIZE_W-1:0];
        CFG_SOURCE_HEIGHT: src_h_q <= cfg_data_i[SIZE_W-1:0];
        CFG_TARGET_WIDTH:  tgt_w_q <= cfg_data_i[TGT_W-1:0];
        CFG_TARGET_HEIGHT: tgt_h_q <= cfg_data_i[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective scale: zero acts as one, large values clamp
  logic [SCALE_W-1:0] k;
  logic [KCNT_W-1:0]  km1;

  always_comb begin
    if (scale_q == '0) begin
      k = SCALE_W'(1);
    end else if (scale_q > SCALE_W'(MAX_SCALE)) begin
      k = SCALE_W'(MAX_SCALE);
    end else begin
      k = scale_q;
    end
    km1 = KCNT_W'(k - SCALE_W'(1));
  end

  // input acceptance
  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // palette table
  pal_req_t            pal_req;
  logic [COLOUR_W-1:0] pal_rdata;

  assign pal_req.wr_en = in_acc && (in_data_i.func == FUNC_PALETTE);
  assign pal_req.rd_en = in_acc && (in_data_i.func == FUNC_PIXEL);
  assign pal_req.addr  = in_data_i.pixel_index;
  assign pal_req.wdata = in_data_i.entry_colour;

  pkiu_palette u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (pal_req),
    .rdata_o (pal_rdata)
  );

  // captured pixel coordinates
  logic [SRC_W-1:0] sx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sx_q <= in_data_i.src_x;
      sy_q <= in_data_i.src_y;
    end
  end

  // shared clip unit: (a+1)*k <= target limit and a < source size;
  // base coordinate a*k = (a+1)*k - k
  logic [SRC_W-1:0]  op_a;
  logic [SIZE_W-1:0] op_src;
  logic [TGT_W-1:0]  op_lim;
  logic [PROD_W-1:0] prod;
  logic              clip_ok;
  logic [DST_W-1:0]  base;

  always_comb begin
    if (state_q == ST_CLIPY) begin
      op_a   = sy_q;
      op_src = src_h_q;
      op_lim = tgt_h_q;
    end else begin
      op_a   = sx_q;
      op_src = src_w_q;
      op_lim = tgt_w_q;
    end
    prod    = PROD_W'({1'b0, op_a} + SIZE_W'(1)) * PROD_W'(k);
    clip_ok = (prod <= PROD_W'(op_lim)) && ({1'b0, op_a} < op_src);
    base    = DST_W'(prod - PROD_W'(k));
  end

  // block walk registers
  logic [DST_W-1:0]  base_x_q;
  logic [DST_W-1:0]  cur_x_q, cur_y_q;
  logic [KCNT_W-1:0] kx_q, ky_q;
  logic              out_free, emit, blk_last, row_end;

  assign out_free = !out_valid_o || !out_stall_i;
  assign emit     = (state_q == ST_EMIT) && out_free;
  assign row_end  = (kx_q == km1);
  assign blk_last = row_end && (ky_q == km1);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLIPX) begin
      base_x_q <= base;
      cur_x_q  <= base;
    end else if (state_q == ST_CLIPY) begin
      cur_y_q <= base;
    end else if (emit) begin
      if (row_end) begin
        cur_x_q <= base_x_q;
        cur_y_q <= cur_y_q + DST_W'(1);
      end else begin
        cur_x_q <= cur_x_q + DST_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kx_q <= '0;
      ky_q <= '0;
    end else if (state_q == ST_CLIPY) begin
      kx_q <= '0;
      ky_q <= '0;
    end else if (emit) begin
      if (row_end) begin
        kx_q <= '0;
        ky_q <= ky_q + KCNT_W'(1);
      end else begin
        kx_q <= kx_q + KCNT_W'(1);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.func == FUNC_PIXEL) &&
            (in_data_i.pixel_index != IDX_TRANSPARENT)) begin
          state_d = ST_CLIPX;
        end
      end
      ST_CLIPX: state_d = clip_ok ? ST_CLIPY : ST_IDLE;
      ST_CLIPY: state_d = clip_ok ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (emit && blk_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  logic      out_valid_q;
  out_beat_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.dst_x  <= cur_x_q;
      out_data_q.dst_y  <= cur_y_q;
      out_data_q.colour <= pal_rdata;
      out_data_q.last   <= blk_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
